>>> rtl/core/frus_pkg.sv
`default_nettype none

package frus_pkg;

	// Field widths.
	localparam int unsigned OpW     = 2;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned WaitW   = 31;
	localparam int unsigned CountW  = 16;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned CfgIdxW = 8;

	// The product (count + 1) * length needs 17 + 16 bits.
	localparam int unsigned McandW = CountW + 1;
	localparam int unsigned ProdW  = McandW + CfgW;

	// One quotient bit per divider step.
	localparam int unsigned DivCntW = 6;
	localparam logic [DivCntW-1:0] DivSteps = DivCntW'(ProdW);

	// Operation codes.
	localparam logic [OpW-1:0] OP_START   = 2'd0;
	localparam logic [OpW-1:0] OP_CHECK   = 2'd1;
	localparam logic [OpW-1:0] OP_ADVANCE = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_UPDATES = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_LENGTH  = 8'd1;

	// Reset values of the configuration registers.
	localparam logic [CfgW-1:0] UpdatesReset = 16'd60;
	localparam logic [CfgW-1:0] LengthReset  = 16'd1000;

	typedef struct packed {
		logic [OpW-1:0]   operation;
		logic [TimeW-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic              update_due;
		logic [WaitW-1:0]  wait_ticks;
		logic [CountW-1:0] updates_last_interval;
		logic [CountW-1:0] updates_this_interval;
	} rsp_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [CfgW-1:0]    value;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [ProdW-1:0] quotient;
		logic [CfgW-1:0]  remainder;
	} div_res_t;

endpackage

`default_nettype wire

>>> rtl/core/frus_if.sv
`default_nettype none

// Request channel: operation and current time.
interface frus_req_if;
	import frus_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Response channel: one result per request.
interface frus_rsp_if;
	import frus_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface frus_cfg_if;
	import frus_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/frus_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module frus_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [frus_pkg::ProdW-1:0] dividend,
	input  logic [frus_pkg::CfgW-1:0]  divisor,
	output frus_pkg::div_stat_t        stat,
	output frus_pkg::div_res_t         res
);
	import frus_pkg::*;

	logic               busy_q;
	logic [DivCntW-1:0] cnt_q;
	logic [ProdW-1:0]   dq_q;
	logic [CfgW-1:0]    rem_q;
	logic [CfgW-1:0]    dvs_q;

	logic [CfgW:0] trial;
	logic [CfgW:0] trial_sub;
	logic          ge;
	logic          stepping;

	// The partial remainder stays below the divisor, so the trial value is
	// below twice the divisor and one subtraction settles each bit.
	assign trial     = {rem_q, dq_q[ProdW-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = (trial >= {1'b0, dvs_q});
	assign stepping  = busy_q && (cnt_q != DivSteps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DivSteps) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (stepping) begin
			dq_q  <= {dq_q[ProdW-2:0], ge};
			rem_q <= ge ? trial_sub[CfgW-1:0] : trial[CfgW-1:0];
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = busy_q && (cnt_q == DivSteps);
	assign res.quotient  = dq_q;
	assign res.remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/fixed_rate_update_scheduler_unit.sv
`default_nettype none
// A start, a taken check or an advance passes ST_MUL (multiply), ST_DIV1 (serial division)
// and ST_DONE, where the result is registered; a rollover adds ST_ROLL, a second division
// in ST_DIV2 and ST_FIN; a check not yet due or an unknown code goes straight to ST_DONE.
// One request at a time, taken in the cycle after the result is registered, so the shared
// serial divider and a receiver that holds off the result set the pace.
// Reset (arst_n low) clears the schedule and counts and loads 60 updates per 1000 ms.

module fixed_rate_update_scheduler_unit (
	input  logic       clk,
	input  logic       arst_n,
	frus_req_if.sink   req,
	frus_rsp_if.source rsp,
	frus_cfg_if.sink   cfg
);
	import frus_pkg::*;

	// The sequencer walks one request through the multiplier and the shared divider.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV1 = 7'b0000100,
		ST_ROLL = 7'b0001000,
		ST_DIV2 = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [CfgW-1:0] upd_q;
	logic [CfgW-1:0] len_q;

	// Schedule state.
	logic [TimeW-1:0]  start_q;
	logic [TimeW-1:0]  end_q;
	logic [TimeW-1:0]  next_q;
	logic [CountW-1:0] cur_q;
	logic [CountW-1:0] last_q;

	// Per-request working registers.
	logic [OpW-1:0]    op_q;
	logic [TimeW-1:0]  now_q;
	logic [McandW-1:0] mcand_q;
	logic              due_q;
	logic [WaitW-1:0]  wait_q;
	logic [ProdW-1:0]  dist_q;

	// Result register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Shared divider.
	logic             div_start;
	logic [ProdW-1:0] div_dividend;
	logic [CfgW-1:0]  div_divisor;
	div_stat_t        div_stat;
	div_res_t         div_res;

	// Request decode.
	logic              accept;
	logic [TimeW-1:0]  now_in;
	logic [TimeW-1:0]  chk_diff;
	logic [TimeW-1:0]  adv_diff;
	logic [CountW-1:0] cnt_inc;
	logic [McandW-1:0] mcand_inc;

	// Rollover arithmetic.
	logic [TimeW-1:0] span;
	logic             roll;
	logic [ProdW-1:0] past_end;
	logic [TimeW-1:0] kl;
	logic [TimeW-1:0] end_new;
	logic             single_step;
	logic             rsp_slot_free;

	assign accept = req.valid && req.ready;
	assign now_in = req.data.now_time;

	// The update is due once now_time has reached the due time, judged wrap-aware
	// over half of the 32-bit range.
	assign chk_diff = now_in - next_q;
	assign adv_diff = next_q - now_in;

	// The update count saturates at its all-ones value.
	assign cnt_inc   = (cur_q == {CountW{1'b1}}) ? cur_q : cur_q + 1'b1;
	assign mcand_inc = {1'b0, cnt_inc} + 1'b1;

	// First division: due offset = (count + 1) * length / updates. The multiplier
	// output is captured by the divider's dividend register.
	// Second division: distance past the interval end divided by the length, where
	// only the remainder and whether the quotient rounds up to one matter.
	assign div_start    = (state_q == ST_MUL) || (state_q == ST_ROLL);
	assign div_dividend = (state_q == ST_MUL) ? (ProdW'(mcand_q) * ProdW'(len_q)) : dist_q;
	assign div_divisor  = (state_q == ST_MUL) ? upd_q : len_q;

	frus_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.res      (div_res)
	);

	// Rollover is judged on offsets from the interval start.
	assign span     = end_q - start_q;
	assign roll     = div_res.quotient > {1'b0, span};
	assign past_end = div_res.quotient - {1'b0, span};

	// The end moves by k whole lengths, k = ceil(past_end / length), which is the
	// distance rounded up to the next multiple of the length. Only the low 32 bits count.
	assign kl = dist_q[TimeW-1:0] - TimeW'(div_res.remainder)
		+ ((div_res.remainder != '0) ? TimeW'(len_q) : '0);
	assign end_new = end_q + kl;

	// k is one when the quotient is zero with a remainder, or one with none.
	assign single_step = (div_res.quotient == '0)
		|| ((div_res.quotient == ProdW'(1)) && (div_res.remainder == '0));

	// The result register may be refilled when empty or when drained this cycle.
	assign rsp_slot_free = !rsp_valid_q || rsp.ready;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Configuration writes; a written zero is stored as one. Unknown indexes are
	// ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= UpdatesReset;
			len_q <= LengthReset;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_UPDATES: begin
					upd_q <= (cfg.data.value == '0) ? CfgW'(1) : cfg.data.value;
				end
				REG_LENGTH: begin
					len_q <= (cfg.data.value == '0) ? CfgW'(1) : cfg.data.value;
				end
				default: begin
				end
			endcase
		end
	end

	// The result is valid from the cycle it is registered until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && rsp_slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			end_q       <= '0;
			next_q      <= '0;
			cur_q       <= '0;
			last_q      <= '0;
			op_q        <= '0;
			now_q       <= '0;
			mcand_q     <= '0;
			due_q       <= 1'b0;
			wait_q      <= '0;
			dist_q      <= '0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= req.data.operation;
						now_q  <= now_in;
						due_q  <= 1'b0;
						wait_q <= '0;
						unique case (req.data.operation)
							OP_START: begin
								// Re-anchor the interval at now_time.
								last_q  <= '0;
								cur_q   <= '0;
								start_q <= now_in;
								end_q   <= now_in + TimeW'(len_q);
								mcand_q <= McandW'(1);
								state_q <= ST_MUL;
							end
							OP_CHECK: begin
								if (!chk_diff[TimeW-1]) begin
									due_q   <= 1'b1;
									cur_q   <= cnt_inc;
									mcand_q <= mcand_inc;
									state_q <= ST_MUL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_ADVANCE: begin
								// Report the time left only when the due time lies ahead.
								if ((adv_diff != '0) && !adv_diff[TimeW-1]) begin
									wait_q <= adv_diff[WaitW-1:0];
								end
								due_q   <= 1'b1;
								cur_q   <= cnt_inc;
								mcand_q <= mcand_inc;
								state_q <= ST_MUL;
							end
							default: begin
								// An unknown code leaves the schedule as it is.
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_stat.done) begin
						if (op_q == OP_START) begin
							next_q  <= now_q + div_res.quotient[TimeW-1:0];
							state_q <= ST_DONE;
						end else begin
							next_q <= start_q + div_res.quotient[TimeW-1:0];
							if (roll) begin
								dist_q  <= past_end;
								state_q <= ST_ROLL;
							end else begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_ROLL: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Skipping more than one interval leaves an empty last interval.
					end_q   <= end_new;
					start_q <= end_new - TimeW'(len_q);
					last_q  <= single_step ? cur_q : '0;
					cur_q   <= '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_slot_free) begin
						rsp_q.update_due            <= due_q;
						rsp_q.wait_ticks            <= wait_q;
						rsp_q.updates_last_interval <= last_q;
						rsp_q.updates_this_interval <= cur_q;
						state_q                     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The divider is never restarted while a division is in flight.
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// A division never sees a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_divisor != '0))
		else $error("zero divisor");

	// Once a request is taken, the block stops taking requests.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while busy");

	// A rollover clears the running count.
	a_roll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (cur_q == '0))
		else $error("count not cleared on rollover");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import frus_pkg::*;

	// Codes the block must tolerate but does not define.
	localparam logic [OpW-1:0]     OP_UNKNOWN = 2'd3;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 8'hFF;

	localparam logic [TimeW-1:0] HalfRange = 32'h8000_0000;

	// The tail outlasts a request with a rollover, so it covers any result still in flight.
	localparam int unsigned TailCycles = 100;
	localparam int unsigned LimitCycles = 2_000_000;
	localparam int unsigned NumBlocks = 12;
	localparam int unsigned BlockItems = 117;
	localparam int unsigned NumPlan = 27;

	typedef enum logic [1:0] {
		ROW_REQ,  // request with an absolute time
		ROW_REL,  // request whose time is an offset from the predicted due time
		ROW_CFG   // register write, issued only once the block has drained
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [OpW-1:0]     op;
		logic [CfgIdxW-1:0] idx;
		logic [TimeW-1:0]   val;
		bit                 typed;
		rsp_t               exp;
	} plan_row_t;

	logic clk;
	logic arst_n;

	frus_req_if req_ch ();
	frus_rsp_if rsp_ch ();
	frus_cfg_if cfg_ch ();

	fixed_rate_update_scheduler_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Directed stimulus. The first rows start from the reset schedule (60 updates per
	// 1000 ms), so their results are simple enough to write down by hand. The rows that
	// are offset from the due time probe the half-range boundary of the wrap-aware
	// compare. Writing zero to both registers gives a one-tick schedule that rolls over
	// on every update; widening the interval afterwards, without a new start, makes the
	// next update skip more than one interval, which must clear the last-interval count.
	plan_row_t plan [NumPlan] = '{
		'{ROW_REQ, OP_UNKNOWN, REG_UPDATES, 32'hFFFF_FFFF, 1'b1, '0},
		'{ROW_REQ, OP_START,   REG_UPDATES, 32'h0000_0000, 1'b1, '0},
		'{ROW_REQ, OP_CHECK,   REG_UPDATES, 32'd15,        1'b1, '0},
		'{ROW_REQ, OP_CHECK,   REG_UPDATES, 32'd16,        1'b1, {1'b1, 31'd0, 16'd0, 16'd1}},
		'{ROW_REQ, OP_ADVANCE, REG_UPDATES, 32'd0,         1'b1, {1'b1, 31'd33, 16'd0, 16'd2}},
		'{ROW_REQ, OP_ADVANCE, REG_UPDATES, 32'd100,       1'b1, {1'b1, 31'd0, 16'd0, 16'd3}},
		'{ROW_REL, OP_CHECK,   REG_UPDATES, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_REL, OP_CHECK,   REG_UPDATES, 32'h8000_0000, 1'b0, '0},
		'{ROW_REL, OP_ADVANCE, REG_UPDATES, 32'h8000_0000, 1'b0, '0},
		'{ROW_REL, OP_ADVANCE, REG_UPDATES, 32'h8000_0001, 1'b0, '0},
		'{ROW_REL, OP_ADVANCE, REG_UPDATES, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, OP_START,   REG_UPDATES, 32'hFFFF_FFF0, 1'b0, '0},
		'{ROW_REL, OP_CHECK,   REG_UPDATES, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, OP_ADVANCE, REG_UPDATES, 32'hFFFF_FFF8, 1'b0, '0},
		'{ROW_CFG, OP_START,   REG_UPDATES, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, OP_START,   REG_LENGTH,  32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, OP_START,   REG_UPDATES, 32'h1234_5678, 1'b0, '0},
		'{ROW_REQ, OP_ADVANCE, REG_UPDATES, 32'h1234_5678, 1'b1, {1'b1, 31'd1, 16'd1, 16'd0}},
		'{ROW_CFG, OP_START,   REG_LENGTH,  32'd100,       1'b0, '0},
		'{ROW_REQ, OP_ADVANCE, REG_UPDATES, 32'h1234_5678, 1'b0, '0},
		'{ROW_CFG, OP_START,   REG_UPDATES, 32'h0000_FFFF, 1'b0, '0},
		'{ROW_CFG, OP_START,   REG_LENGTH,  32'h0000_FFFF, 1'b0, '0},
		'{ROW_CFG, OP_START,   REG_UNUSED,  32'h0000_1234, 1'b0, '0},
		'{ROW_REQ, OP_START,   REG_UPDATES, 32'h8000_0000, 1'b0, '0},
		'{ROW_REL, OP_ADVANCE, REG_UPDATES, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REQ, OP_CHECK,   REG_UPDATES, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, OP_UNKNOWN, REG_UPDATES, 32'h5555_5555, 1'b0, '0}
	};

	// Our own copy of the schedule: configuration, anchors and counts.
	logic [CfgW-1:0]   sch_updates;
	logic [CfgW-1:0]   sch_length;
	logic [TimeW-1:0]  sch_start;
	logic [TimeW-1:0]  sch_end;
	logic [TimeW-1:0]  sch_next;
	logic [CountW-1:0] sch_count;
	logic [CountW-1:0] sch_last;

	// Results predicted for accepted requests, oldest first.
	rsp_t schedule_rsp_q [$];

	int unsigned mismatches = 0;
	int unsigned snd_idle_pct = 33;
	int unsigned rcv_idle_pct = 79;
	int unsigned hold_left = 0;

	// Offset of the next due time from the interval start, exact product then floor.
	function automatic longint unsigned due_offset(logic [CountW-1:0] cnt);
		longint unsigned c;
		longint unsigned l;
		longint unsigned u;
		c = cnt;
		l = sch_length;
		u = sch_updates;
		return ((c + 1) * l) / u;
	endfunction

	// Takes one update: the count saturates, the due time moves on, and when it lands
	// past the interval end the interval rolls over by as many lengths as needed.
	function automatic void take_update();
		longint unsigned off;
		longint unsigned span;
		longint unsigned hops;
		logic [TimeW-1:0] span32;
		if (sch_count != '1)
			sch_count = sch_count + 1'b1;
		off = due_offset(sch_count);
		sch_next = sch_start + off[TimeW-1:0];
		span32 = sch_end - sch_start;
		span = span32;
		if (off > span) begin
			hops = (off - span + sch_length - 1) / sch_length;
			sch_end = sch_end + TimeW'(hops * sch_length);
			sch_start = sch_end - sch_length;
			// Skipped intervals held no updates, so a multi-interval jump reports zero.
			sch_last = (hops == 1) ? sch_count : '0;
			sch_count = '0;
		end
	endfunction

	function automatic rsp_t schedule_step(req_t r);
		rsp_t o;
		logic [TimeW-1:0] diff;
		o = '0;
		case (r.operation)
			OP_START: begin
				sch_last = '0;
				sch_count = '0;
				sch_start = r.now_time;
				sch_end = r.now_time + sch_length;
				sch_next = r.now_time + TimeW'(due_offset('0));
			end
			OP_CHECK: begin
				diff = r.now_time - sch_next;
				if (diff < HalfRange) begin
					o.update_due = 1'b1;
					take_update();
				end
			end
			OP_ADVANCE: begin
				diff = sch_next - r.now_time;
				if (diff != '0 && diff < HalfRange)
					o.wait_ticks = diff[WaitW-1:0];
				o.update_due = 1'b1;
				take_update();
			end
			default: begin
				// An unknown code leaves the schedule alone.
			end
		endcase
		o.updates_last_interval = sch_last;
		o.updates_this_interval = sch_count;
		return o;
	endfunction

	function automatic void schedule_config(cfg_t c);
		logic [CfgW-1:0] v;
		v = (c.value == '0) ? CfgW'(1) : c.value;
		if (c.index == REG_UPDATES)
			sch_updates = v;
		else if (c.index == REG_LENGTH)
			sch_length = v;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Offers one request from the falling edge on and holds it until the block takes
	// it. The prediction is made at the accepting edge, so it sees every earlier request.
	task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t p;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data = r;
		do @(posedge clk); while (!req_ch.ready);
		p = schedule_step(r);
		schedule_rsp_q.push_back(typed ? typed_rsp : p);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
		cfg_t c;
		c.index = idx;
		c.value = val;
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = c;
		do @(posedge clk); while (!cfg_ch.ready);
		schedule_config(c);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Stops offering requests and waits until every predicted result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (schedule_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: ready changes on the falling edge. A long hold-off, when requested,
	// is counted down here so the request side keeps offering while the block stalls.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// Each result transaction is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (schedule_rsp_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, got %h", $time,
					rsp_ch.data);
			end else begin
				want = schedule_rsp_q.pop_front();
				check_field("update_due", want.update_due, rsp_ch.data.update_due);
				check_field("wait_ticks", want.wait_ticks, rsp_ch.data.wait_ticks);
				check_field("updates_last_interval", want.updates_last_interval,
					rsp_ch.data.updates_last_interval);
				check_field("updates_this_interval", want.updates_this_interval,
					rsp_ch.data.updates_this_interval);
			end
		end
	end

	initial begin
		req_t item;
		logic [TimeW-1:0] tick;
		int unsigned nominal;
		int unsigned dice;
		logic [CfgW-1:0] upd_w;
		logic [CfgW-1:0] len_w;

		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;

		sch_updates = UpdatesReset;
		sch_length = LengthReset;
		sch_start = '0;
		sch_end = '0;
		sch_next = '0;
		sch_count = '0;
		sch_last = '0;

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, run under the first idling mix.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_for_results();
				write_reg(plan[i].idx, plan[i].val[CfgW-1:0]);
			end else begin
				item.operation = plan[i].op;
				item.now_time = (plan[i].kind == ROW_REL) ? sch_next + plan[i].val
					: plan[i].val;
				send_request(item, plan[i].typed, plan[i].exp);
			end
		end

		// Random part: twelve blocks of requests. The first four run with a slow receiver,
		// the next four with a slow sender, and the last four with no idling at all.
		// Every block starts drained and under a fresh setting; the fixed settings cover
		// the reset values and the corners of both registers.
		for (int unsigned b = 0; b < NumBlocks; b++) begin
			wait_for_results();
			snd_idle_pct = (b < 4) ? 33 : (b < 8) ? 79 : 0;
			rcv_idle_pct = (b < 4) ? 79 : (b < 8) ? 33 : 0;
			case (b)
				0: begin
					upd_w = UpdatesReset;
					len_w = LengthReset;
				end
				1: begin
					upd_w = 16'd1;
					len_w = 16'd1;
				end
				2: begin
					upd_w = 16'hFFFF;
					len_w = 16'hFFFF;
				end
				3: begin
					upd_w = 16'd1;
					len_w = 16'hFFFF;
				end
				4: begin
					upd_w = 16'hFFFF;
					len_w = 16'd1;
				end
				default: begin
					upd_w = CfgW'($urandom_range(0, 300));
					len_w = CfgW'($urandom_range(0, 5000));
				end
			endcase
			write_reg(REG_UPDATES, upd_w);
			write_reg(REG_LENGTH, len_w);

			// With the block drained and the receiver holding off for a long stretch, the first
			// result fills the result register, the next request stalls the block, and later ones pile up at its input.
			if (b == 8)
				hold_left = 400;

			tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
				: $urandom;
			nominal = sch_length / sch_updates + 1;

			// Most blocks re-anchor first; the others keep the anchors of the last block,
			// so the new setting applies to a schedule already under way.
			if ($urandom_range(0, 3) != 0) begin
				item.operation = OP_START;
				item.now_time = tick;
				send_request(item, 1'b0, '0);
			end

			for (int unsigned n = 0; n < BlockItems; n++) begin
				dice = $urandom_range(0, 99);
				if (dice < 3) begin
					item.operation = OP_START;
					item.now_time = tick;
				end else if (dice < 6) begin
					item.operation = OP_UNKNOWN;
					item.now_time = $urandom;
				end else if (dice < 10) begin
					// Noise: any code at any time.
					item.operation = OpW'($urandom_range(0, 3));
					item.now_time = $urandom;
				end else if (dice < 45) begin
					tick = tick + $urandom_range(0, 2 * nominal);
					item.operation = OP_ADVANCE;
					item.now_time = tick;
				end else begin
					// Checks follow a clock that runs at roughly the update rate; some
					// land right around the due time to hit both sides of it.
					tick = tick + $urandom_range(0, nominal);
					item.operation = OP_CHECK;
					item.now_time = ($urandom_range(0, 3) == 0)
						? sch_next + $urandom_range(0, 2) - 1 : tick;
				end
				send_request(item, 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#(LimitCycles * 4);
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> fixed_rate_update_scheduler_unit.f
rtl/core/frus_pkg.sv
rtl/core/frus_if.sv
rtl/core/frus_div.sv
rtl/core/fixed_rate_update_scheduler_unit.sv
test/tb.sv
